>>> rtl/ble_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded ordered list engine.
// Holds request and status codes, the controller state type and the
// command/status structs shared by ble_ctrl and ble_dp. No dependencies.
package ble_pkg;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;

    localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_POS   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REM_POS   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic match;        // latch the per-cell compare vector
        logic commit_op;    // apply insert/remove and load the result
        logic commit_find;  // load the search result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_search;
    } t_dp_stat;

endpackage

>>> rtl/ble_ctrl.sv
`timescale 1ns / 1ps
// Controller for the bounded ordered list engine.
// Sequences capture, execute and search steps and owns the output valid flag.
// Depends on ble_pkg.
module ble_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  ble_pkg::t_dp_stat  i_stat,
    output ble_pkg::t_dp_cmd   o_cmd
);

    ble_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_slot_free;

    // output register can take a new result this cycle
    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ble_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = ble_pkg::S_EXEC;
                end
            end
            ble_pkg::S_EXEC: begin
                if (i_stat.is_search) begin
                    n_state = ble_pkg::S_FIND;
                end else if (w_slot_free) begin
                    n_state = ble_pkg::S_IDLE;
                end
            end
            ble_pkg::S_FIND: begin
                if (w_slot_free) begin
                    n_state = ble_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ble_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ble_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            ble_pkg::S_EXEC: begin
                o_cmd.match     = 1'b1;
                o_cmd.commit_op = !i_stat.is_search && w_slot_free;
            end
            ble_pkg::S_FIND: begin
                o_cmd.commit_find = w_slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit_op || o_cmd.commit_find) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ble_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ble_pkg::S_EXEC))
        else $error("accepted request did not enter execute");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_op || o_cmd.commit_find) |=> r_out_valid)
        else $error("committed result not presented");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit_op && o_cmd.commit_find))
        else $error("two commits in one cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_op || o_cmd.commit_find) |-> (!r_out_valid || i_ready))
        else $error("result overwritten before transfer");

endmodule

>>> rtl/ble_dp.sv
`timescale 1ns / 1ps
// Datapath for the bounded ordered list engine.
// Row of value cells that shift for insert/remove, a compare vector for
// search, the entry count and the result register. Depends on ble_pkg.
module ble_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ble_pkg::t_dp_cmd                    i_cmd,
    output ble_pkg::t_dp_stat                   o_stat,
    input  logic [ble_pkg::REQ_W-1:0]           i_req_type,
    input  logic [ble_pkg::POS_W-1:0]           i_position,
    input  logic signed [ble_pkg::VALUE_W-1:0]  i_value,
    output logic [ble_pkg::STATUS_W-1:0]        o_status,
    output logic [ble_pkg::POS_W-1:0]           o_found_position,
    output logic [ble_pkg::POS_W-1:0]           o_entry_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > ble_pkg::POS_W) ? CW : ble_pkg::POS_W) + 1;

    logic [ble_pkg::REQ_W-1:0]           r_req;
    logic [ble_pkg::POS_W-1:0]           r_pos;
    logic signed [ble_pkg::VALUE_W-1:0]  r_val;
    logic signed [ble_pkg::VALUE_W-1:0]  r_cell [CAPACITY];
    logic signed [ble_pkg::VALUE_W-1:0]  n_cell [CAPACITY];
    logic [CAPACITY-1:0]                 r_match;
    logic [CW-1:0]                       r_count, n_count;
    logic [ble_pkg::STATUS_W-1:0]        r_status, n_status;
    logic [ble_pkg::POS_W-1:0]           r_found, n_found;
    logic [ble_pkg::POS_W-1:0]           r_count_out, n_count_out;

    logic [CMPW-1:0]              w_cnt_x, w_pos_x, w_idx;
    logic                         w_full, w_empty, w_ins, w_rem;
    logic [ble_pkg::STATUS_W-1:0] w_op_status;
    logic [CAPACITY-1:0]          w_low;
    logic [IW-1:0]                w_hit_idx;
    logic [CMPW-1:0]              w_hit_pos;

    assign o_stat.is_search = (r_req == ble_pkg::REQ_SEARCH);

    assign w_cnt_x = CMPW'(r_count);
    assign w_pos_x = CMPW'(r_pos);
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    // decode the request into an insert or remove at one index
    always_comb begin
        w_ins       = 1'b0;
        w_rem       = 1'b0;
        w_idx       = '0;
        w_op_status = ble_pkg::ST_OK;
        case (r_req)
            ble_pkg::REQ_ADD_FRONT, ble_pkg::REQ_ADD_BACK, ble_pkg::REQ_ADD_POS: begin
                if (w_full) begin
                    w_op_status = ble_pkg::ST_FULL;
                end else if (r_req == ble_pkg::REQ_ADD_FRONT) begin
                    w_ins = 1'b1;
                end else if (r_req == ble_pkg::REQ_ADD_BACK) begin
                    w_ins = 1'b1;
                    w_idx = w_cnt_x;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x + 1'b1) begin
                    w_op_status = ble_pkg::ST_BADPOS;
                end else begin
                    w_ins = 1'b1;
                    w_idx = w_pos_x - 1'b1;
                end
            end
            ble_pkg::REQ_REM_FRONT, ble_pkg::REQ_REM_BACK, ble_pkg::REQ_REM_POS: begin
                if (w_empty) begin
                    w_op_status = ble_pkg::ST_EMPTY;
                end else if (r_req == ble_pkg::REQ_REM_FRONT) begin
                    w_rem = 1'b1;
                end else if (r_req == ble_pkg::REQ_REM_BACK) begin
                    w_rem = 1'b1;
                    w_idx = w_cnt_x - 1'b1;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                    w_op_status = ble_pkg::ST_BADPOS;
                end else begin
                    w_rem = 1'b1;
                    w_idx = w_pos_x - 1'b1;
                end
            end
            default: begin
                w_op_status = ble_pkg::ST_OK;
            end
        endcase
    end

    // each cell picks from its left neighbor, its right neighbor or the new value
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [CMPW-1:0] KC = CMPW'(k);
        always_comb begin
            n_cell[k] = r_cell[k];
            if (i_cmd.commit_op && w_ins) begin
                if (KC == w_idx) begin
                    n_cell[k] = r_val;
                end else if (KC > w_idx) begin
                    if (k > 0) begin
                        n_cell[k] = r_cell[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (i_cmd.commit_op && w_rem) begin
                if (KC >= w_idx) begin
                    if (k < CAPACITY - 1) begin
                        n_cell[k] = r_cell[(k < CAPACITY - 1) ? k + 1 : k];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[k] <= n_cell[k];
            if (i_cmd.match) begin
                r_match[k] <= (r_cell[k] == r_val) && (KC < w_cnt_x);
            end
        end
    end

    // isolate the first match and encode its index
    assign w_low = r_match & (~r_match + 1'b1);

    always_comb begin
        w_hit_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_hit_idx = w_hit_idx | (w_low[k] ? IW'(k) : '0);
        end
    end

    assign w_hit_pos = CMPW'(w_hit_idx) + 1'b1;

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_found     = r_found;
        n_count_out = r_count_out;
        if (i_cmd.commit_op) begin
            n_count     = r_count + CW'(w_ins) - CW'(w_rem);
            n_status    = w_op_status;
            n_found     = '0;
            n_count_out = ble_pkg::POS_W'(n_count);
        end else if (i_cmd.commit_find) begin
            n_status    = (|r_match) ? ble_pkg::ST_OK : ble_pkg::ST_NOTFOUND;
            n_found     = (|r_match) ? w_hit_pos[ble_pkg::POS_W-1:0] : '0;
            n_count_out = ble_pkg::POS_W'(w_cnt_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_status    <= n_status;
        r_found     <= n_found;
        r_count_out <= n_count_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_entry_count    = r_count_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_op && w_ins) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_op && w_rem) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("remove did not shrink the list");

endmodule

>>> rtl/bounded_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// Bounded ordered list engine: insert, remove and search on a list of values.
// A result is registered by the execute step, or by the find step after it for
// a search; either step waits while the output holds a result not yet taken.
// A new request is accepted only in the idle state, after the last one committed.
// Reset: synchronous active-low; clears the entry count, controller and output
// valid. Cell contents are not cleared and are never read beyond the count.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ble_pkg::REQ_W-1:0]           i_req_type,
    input  logic [ble_pkg::POS_W-1:0]           i_position,
    input  logic signed [ble_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ble_pkg::STATUS_W-1:0]        o_status,
    output logic [ble_pkg::POS_W-1:0]           o_found_position,
    output logic [ble_pkg::POS_W-1:0]           o_entry_count
);

    ble_pkg::t_dp_cmd  w_cmd;
    ble_pkg::t_dp_stat w_stat;

    ble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ble_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

endmodule
